@@ rtl/asps_pkg.sv @@
// Shared types, sizes and status codes for the aging priority scheduler.
package asps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam logic [2:0] ST_ADD_OK   = 3'd0;
  localparam logic [2:0] ST_ADD_REJ  = 3'd1;
  localparam logic [2:0] ST_IDLE     = 3'd2;
  localparam logic [2:0] ST_RAN_WAIT = 3'd3;
  localparam logic [2:0] ST_RAN_FIN  = 3'd4;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] run;
    logic [15:0] done;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic add;
    logic idle_tick;
    logic sort_step;
    logic copy;
    logic run;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic pending;
    logic sort_last;
    logic finished;
  } dp_stat_t;

endpackage

@@ rtl/asps_dp.sv @@
// Datapath: process table, insertion-sort row, counters and result registers.
module asps_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  asps_pkg::dp_cmd_t      cmd,
  output asps_pkg::dp_stat_t     stat,
  input  logic [15:0]            proc_id,
  input  logic [7:0]             start_priority,
  input  logic [15:0]            run_length,
  output logic [2:0]             status,
  output logic [15:0]            ran_id,
  output logic [31:0]            tick_number,
  output logic [15:0]            time_left,
  output logic [7:0]             new_priority,
  output logic [4:0]             live_count
);
  import asps_pkg::*;

  slot_t             table_r [MAX_PROCS];
  slot_t             table_r_next [MAX_PROCS];
  slot_t             tmp [MAX_PROCS];
  slot_t             tmp_next [MAX_PROCS];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  placed;
  logic [31:0]       ran_ticks;
  logic              pending;
  logic [MAX_PROCS-1:0] lt;
  slot_t             cur;
  slot_t             head;
  logic [15:0]       done1;
  logic              finished;
  logic              add_ok;

  assign cur      = table_r[0];
  assign head     = table_r[0];
  assign done1    = head.done + 16'd1;
  assign finished = (done1 >= head.run);
  assign add_ok   = (count < CNT_W'(MAX_PROCS)) && (run_length != 16'd0);

  assign stat.count_zero = (count == '0);
  assign stat.pending    = pending;
  assign stat.sort_last  = (placed == count - CNT_W'(1));
  assign stat.finished   = finished;

  assign tick_number = ran_ticks;
  assign live_count  = 5'(count);

  // Placed entries whose priority is below the one being inserted
  always_comb begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      lt[k] = (CNT_W'(k) < placed) && (tmp[k].prio < cur.prio);
    end
  end

  // Next table and sort row
  always_comb begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      table_r_next[k] = table_r[k];
      tmp_next[k]     = tmp[k];
    end
    if (cmd.sort_step) begin
      for (int k = 0; k < MAX_PROCS - 1; k++) begin
        table_r_next[k] = table_r[k + 1];
      end
      tmp_next[0] = lt[0] ? tmp[0] : cur;
      for (int k = 1; k < MAX_PROCS; k++) begin
        if (lt[k]) begin
          tmp_next[k] = tmp[k];
        end else if (lt[k - 1]) begin
          tmp_next[k] = cur;
        end else begin
          tmp_next[k] = tmp[k - 1];
        end
      end
    end
    if (cmd.copy) begin
      for (int k = 0; k < MAX_PROCS; k++) begin
        table_r_next[k] = tmp[k];
      end
    end
    if (cmd.add && add_ok) begin
      table_r_next[count[IDX_W-1:0]] = '{id: proc_id, prio: start_priority,
                                         run: run_length, done: 16'd0};
    end
    if (cmd.run) begin
      if (finished) begin
        for (int k = 0; k < MAX_PROCS - 1; k++) begin
          table_r_next[k] = table_r[k + 1];
        end
      end else begin
        table_r_next[0].done = done1;
        if (head.prio != 8'hFF) begin
          table_r_next[0].prio = head.prio + 8'd1;
        end
      end
    end
  end

  // Table and sort row storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      table_r[k] <= table_r_next[k];
      tmp[k]     <= tmp_next[k];
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      placed    <= '0;
      ran_ticks <= '0;
      pending   <= 1'b0;
    end else begin
      placed <= cmd.sort_step ? placed + CNT_W'(1) : '0;
      if (cmd.add && add_ok) begin
        count   <= count + CNT_W'(1);
        pending <= 1'b1;
      end
      if (cmd.copy) begin
        pending <= 1'b0;
      end
      if (cmd.run) begin
        ran_ticks <= ran_ticks + 32'd1;
        if (finished) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      status       <= add_ok ? ST_ADD_OK : ST_ADD_REJ;
      ran_id       <= 16'd0;
      time_left    <= 16'd0;
      new_priority <= 8'd0;
    end else if (cmd.idle_tick) begin
      status       <= ST_IDLE;
      ran_id       <= 16'd0;
      time_left    <= 16'd0;
      new_priority <= 8'd0;
    end else if (cmd.run) begin
      ran_id <= head.id;
      if (finished) begin
        status       <= ST_RAN_FIN;
        time_left    <= 16'd0;
        new_priority <= head.prio;
      end else begin
        status       <= ST_RAN_WAIT;
        time_left    <= head.run - done1;
        new_priority <= (head.prio != 8'hFF) ? head.prio + 8'd1 : head.prio;
      end
    end
  end

endmodule

@@ rtl/asps_ctrl.sv @@
// Controller: sequences add, sort, copy and run steps for each transaction.
module asps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  input  asps_pkg::dp_stat_t  stat,
  output asps_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                done
);
  import asps_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;
  localparam logic [1:0] S_RUN  = 2'd3;

  logic [1:0] state, state_next;
  logic       after_run, after_run_next;
  logic       done_next;

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    after_run_next = after_run;
    done_next      = 1'b0;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_ADD) begin
            cmd.add   = 1'b1;
            done_next = 1'b1;
          end else if (stat.count_zero) begin
            cmd.idle_tick = 1'b1;
            done_next     = 1'b1;
          end else if (stat.pending) begin
            state_next     = S_SORT;
            after_run_next = 1'b0;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (stat.sort_last) begin
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (after_run) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (stat.finished) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next     = S_SORT;
          after_run_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      after_run <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      after_run <= after_run_next;
      done      <= done_next;
    end
  end

endmodule

@@ rtl/aging_priority_scheduler.sv @@
// Adds and empty ticks need no sort; others sort new adds, run, re-sort if unfinished.
// Each sort pass feeds one table entry per cycle through the insertion row, plus one copy.
// One transaction at a time; busy is high while a tick is in work; done strobes one cycle.
// The receiver cannot stall; results are registered and held until the next command.
// Synchronous reset empties the table, clears the tick count and the sort mark.
module aging_priority_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [15:0] proc_id,
  input  logic [7:0]  start_priority,
  input  logic [15:0] run_length,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] ran_id,
  output logic [31:0] tick_number,
  output logic [15:0] time_left,
  output logic [7:0]  new_priority,
  output logic [4:0]  live_count
);
  import asps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  asps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  asps_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .proc_id        (proc_id),
    .start_priority (start_priority),
    .run_length     (run_length),
    .status         (status),
    .ran_id         (ran_id),
    .tick_number    (tick_number),
    .time_left      (time_left),
    .new_priority   (new_priority),
    .live_count     (live_count)
  );

endmodule

@@ tb/tb_aging_priority_scheduler.sv @@
// Self-checking testbench for the aging priority scheduler: queued commands, predicted results.
`timescale 1ns / 1ps

module tb_aging_priority_scheduler;
  import asps_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [15:0] proc_id;
  logic [7:0]  start_priority;
  logic [15:0] run_length;
  logic        done;
  logic [2:0]  status;
  logic [15:0] ran_id;
  logic [31:0] tick_number;
  logic [15:0] time_left;
  logic [7:0]  new_priority;
  logic [4:0]  live_count;

  typedef struct packed {
    logic        cmd;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] run;
  } sched_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] ran_id;
    logic [31:0] tick_number;
    logic [15:0] time_left;
    logic [7:0]  new_priority;
    logic [4:0]  live_count;
  } sched_res_t;

  sched_cmd_t pending_cmds[$];
  sched_res_t expected_res[$];
  int         err_count;
  bit         stim_done;
  bit         calm;

  // Shadow scheduler state
  slot_t       shadow_tbl[MAX_PROCS];
  int          shadow_cnt;
  logic [31:0] shadow_ticks;
  bit          shadow_dirty;

  aging_priority_scheduler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .proc_id(proc_id), .start_priority(start_priority), .run_length(run_length),
    .done(done), .status(status), .ran_id(ran_id), .tick_number(tick_number),
    .time_left(time_left), .new_priority(new_priority), .live_count(live_count)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Insertion sort, ascending priority; ties come out reversed
  function automatic void sort_shadow();
    slot_t tmp[MAX_PROCS];
    int    placed;
    int    p;
    placed = 0;
    for (int i = 0; i < shadow_cnt; i++) begin
      p = 0;
      while (p < placed && tmp[p].prio < shadow_tbl[i].prio) p++;
      for (int k = placed; k > p; k--) tmp[k] = tmp[k-1];
      tmp[p] = shadow_tbl[i];
      placed++;
    end
    for (int i = 0; i < shadow_cnt; i++) shadow_tbl[i] = tmp[i];
  endfunction

  function automatic sched_res_t schedule_step(sched_cmd_t c);
    sched_res_t r;
    r = '0;
    if (c.cmd == CMD_ADD) begin
      if (shadow_cnt >= MAX_PROCS || c.run == 16'd0) begin
        r.status = ST_ADD_REJ;
      end else begin
        shadow_tbl[shadow_cnt] = '{id: c.id, prio: c.prio, run: c.run, done: 16'd0};
        shadow_cnt++;
        shadow_dirty = 1'b1;
        r.status = ST_ADD_OK;
      end
    end else begin
      if (shadow_dirty) begin
        sort_shadow();
        shadow_dirty = 1'b0;
      end
      if (shadow_cnt == 0) begin
        r.status = ST_IDLE;
      end else begin
        shadow_ticks++;
        shadow_tbl[0].done++;
        r.ran_id = shadow_tbl[0].id;
        if (shadow_tbl[0].done >= shadow_tbl[0].run) begin
          r.status = ST_RAN_FIN;
          r.new_priority = shadow_tbl[0].prio;
          for (int i = 1; i < shadow_cnt; i++) shadow_tbl[i-1] = shadow_tbl[i];
          shadow_cnt--;
        end else begin
          r.status = ST_RAN_WAIT;
          r.time_left = shadow_tbl[0].run - shadow_tbl[0].done;
          if (shadow_tbl[0].prio != 8'hFF) shadow_tbl[0].prio++;
          r.new_priority = shadow_tbl[0].prio;
          sort_shadow();
        end
      end
    end
    r.tick_number = shadow_ticks;
    r.live_count  = shadow_cnt[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $realtime);
    err_count++;
  endtask

  // Driver: pops commands, predicts on acceptance, idles in bursts
  int drv_gap;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      drv_gap = 0;
    end else begin
      if (start && !busy) expected_res.push_back(schedule_step(pending_cmds.pop_front()));
      if (!(start && busy)) begin
        if (drv_gap > 0) drv_gap--;
        else if (!calm && $urandom_range(0, 9) == 0) drv_gap = $urandom_range(1, 16);
        if (drv_gap == 0 && pending_cmds.size() > (start && !busy ? 0 : 0)) begin
          start          <= 1'b1;
          command        <= pending_cmds[0].cmd;
          proc_id        <= pending_cmds[0].id;
          start_priority <= pending_cmds[0].prio;
          run_length     <= pending_cmds[0].run;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  sched_res_t want;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        err_count++;
      end else begin
        want = expected_res.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (ran_id !== want.ran_id)
          report_mismatch("ran_id", 32'(ran_id), 32'(want.ran_id));
        if (tick_number !== want.tick_number)
          report_mismatch("tick_number", tick_number, want.tick_number);
        if (time_left !== want.time_left)
          report_mismatch("time_left", 32'(time_left), 32'(want.time_left));
        if (new_priority !== want.new_priority)
          report_mismatch("new_priority", 32'(new_priority), 32'(want.new_priority));
        if (live_count !== want.live_count)
          report_mismatch("live_count", 32'(live_count), 32'(want.live_count));
      end
    end
  end

  function automatic sched_cmd_t mk(logic cmd, logic [15:0] id, logic [7:0] pr,
                                    logic [15:0] rl);
    sched_cmd_t c;
    c = '{cmd: cmd, id: id, prio: pr, run: rl};
    return c;
  endfunction

  // Random command; mostly short jobs so entries finish and the table churns
  function automatic sched_cmd_t rand_cmd(int add_pct);
    sched_cmd_t c;
    int         sel;
    c.cmd  = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_TICK;
    c.id   = 16'($urandom());
    sel = $urandom_range(0, 9);
    c.prio = (sel < 2) ? 8'(8'hFF - $urandom_range(0, 2))
             : (sel < 5 ? 8'($urandom_range(0, 7)) : 8'($urandom()));
    sel = $urandom_range(0, 19);
    c.run  = (sel == 0) ? 16'd0
             : (sel == 1 ? 16'($urandom()) : 16'($urandom_range(1, 6)));
    return c;
  endfunction

  // Stimulus
  initial begin
    start = 1'b0; command = CMD_ADD; proc_id = '0; start_priority = '0; run_length = '0;
    err_count = 0; stim_done = 0; calm = 0;
    shadow_cnt = 0; shadow_ticks = '0; shadow_dirty = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed: idle tick, zero run, extremes, ties, full table
    pending_cmds.push_back(mk(CMD_TICK, 16'h0, 8'h0, 16'h0));
    pending_cmds.push_back(mk(CMD_ADD, 16'hFFFF, 8'hFF, 16'h0));
    pending_cmds.push_back(mk(CMD_ADD, 16'hFFFF, 8'hFF, 16'h3));
    pending_cmds.push_back(mk(CMD_ADD, 16'h0000, 8'h00, 16'hFFFF));
    pending_cmds.push_back(mk(CMD_ADD, 16'h1111, 8'h05, 16'h1));
    pending_cmds.push_back(mk(CMD_ADD, 16'h2222, 8'h05, 16'h2));
    for (int i = 0; i < 12; i++)
      pending_cmds.push_back(mk(CMD_ADD, 16'(16'h100 + i), 8'hFE, 16'h1));
    pending_cmds.push_back(mk(CMD_ADD, 16'hAAAA, 8'h10, 16'h1));
    for (int i = 0; i < 5; i++) pending_cmds.push_back(mk(CMD_TICK, 16'hFFFF, 8'hFF, 16'hFFFF));
    // Then a random mix of adds and ticks
    for (int i = 0; i < 840; i++) begin
      pending_cmds.push_back(rand_cmd((i / 60) % 3 == 0 ? 70 : 45));
      if (i == 780) calm = 1;
      while (pending_cmds.size() > 8) @(posedge clk);
    end
    while (pending_cmds.size() > 0) @(posedge clk);
    calm = 1;
    while (start || expected_res.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0 && expected_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/asps_pkg.sv
rtl/asps_dp.sv
rtl/asps_ctrl.sv
rtl/aging_priority_scheduler.sv
tb/tb_aging_priority_scheduler.sv
